// ----- hdl/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

  // Leading-bit tags of the byte classes
  localparam logic [3:0] LEAD3_TAG = 4'b1110;  // 1110xxxx
  localparam logic [2:0] LEAD2_TAG = 3'b110;   // 110xxxxx
  localparam logic [1:0] CONT_TAG  = 2'b10;    // 10xxxxxx

  localparam int unsigned PartialWidth = 10;
  localparam int unsigned CodeWidth    = 16;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEAD = 2'd1,
    ERR_CONT = 2'd2,
    ERR_END  = 2'd3
  } err_kind_t;

  // Decoder state carried between bytes
  typedef struct packed {
    logic [PartialWidth-1:0] partial_bits;
    logic [1:0]              bytes_pending;
  } dec_state_t;

  // One decoded result
  typedef struct packed {
    logic [CodeWidth-1:0] code_point;
    err_kind_t            error_kind;
    logic                 string_done;
  } dec_result_t;

endpackage

// ----- hdl/utd_in_if.sv -----
// ----------------------------------------------------------------------------
// utd_in_if
// Byte channel into the decoder: one raw byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface utd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_string;

  modport source (output valid, output byte_value, output end_of_string, input ready);
  modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

// ----- hdl/utd_out_if.sv -----
// ----------------------------------------------------------------------------
// utd_out_if
// Result channel out of the decoder: code point, error code, string close.
// ----------------------------------------------------------------------------
interface utd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic [1:0]  error_kind;
  logic        string_done;

  modport source (output valid, output code_point, output error_kind,
                  output string_done, input ready);
  modport sink   (input valid, input code_point, input error_kind,
                  input string_done, output ready);
endinterface

// ----- hdl/utd_decode.sv -----
// ----------------------------------------------------------------------------
// utd_decode
// Combinational decode of one byte against the current sequence state.
// ----------------------------------------------------------------------------
module utd_decode
  import utd_pkg::*;
(
  input  dec_state_t  state,
  input  logic [7:0]  byte_value,
  input  logic        end_of_string,
  output dec_state_t  state_next,
  output logic        emit,
  output dec_result_t result
);

  logic lead3;
  logic lead2;
  logic cont;

  assign lead3 = (byte_value[7:4] == LEAD3_TAG);
  assign lead2 = (byte_value[7:5] == LEAD2_TAG);
  assign cont  = (byte_value[7:6] == CONT_TAG);

  always_comb begin
    state_next         = state;
    emit               = 1'b0;
    result.code_point  = '0;
    result.error_kind  = ERR_NONE;
    result.string_done = end_of_string;

    if (state.bytes_pending == 2'd0) begin
      if (lead3 || lead2) begin
        if (end_of_string) begin
          // lead byte is the last byte: sequence can never complete
          state_next        = '0;
          emit              = 1'b1;
          result.error_kind = ERR_END;
        end else if (lead3) begin
          state_next.partial_bits  = {6'd0, byte_value[3:0]};
          state_next.bytes_pending = 2'd2;
        end else begin
          state_next.partial_bits  = {5'd0, byte_value[4:0]};
          state_next.bytes_pending = 2'd1;
        end
      end else if (!byte_value[7]) begin
        emit              = 1'b1;
        result.code_point = {8'd0, byte_value};
      end else begin
        state_next        = '0;
        emit              = 1'b1;
        result.error_kind = ERR_LEAD;
      end
    end else begin
      if (end_of_string && state.bytes_pending[1]) begin
        // end check outranks the prefix check
        state_next        = '0;
        emit              = 1'b1;
        result.error_kind = ERR_END;
      end else if (!cont) begin
        state_next        = '0;
        emit              = 1'b1;
        result.error_kind = ERR_CONT;
      end else if (state.bytes_pending[1]) begin
        state_next.partial_bits  = {state.partial_bits[3:0], byte_value[5:0]};
        state_next.bytes_pending = 2'd1;
      end else begin
        state_next        = '0;
        emit              = 1'b1;
        result.code_point = {state.partial_bits, byte_value[5:0]};
      end
    end
  end

endmodule

// ----- hdl/utf8_to_ucs2_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit
// Streaming UTF-8 decoder for 1-, 2- and 3-byte forms, 16-bit results.
// ----------------------------------------------------------------------------
// The unit takes one byte per transaction and sustains one byte per clock
// while the result side is not stalled. Each byte passes an input register,
// then a single pass of decode logic into the result register, which loads
// only when it is free or being drained. A lead byte that opens a sequence
// and the middle byte of a 3-byte form give no result unless flagged as the
// end of the string; every other byte gives exactly one. Errors (bad
// lead byte, missing continuation prefix, string ending inside a sequence)
// give one result with a zero code point, drop the partial character and the
// offending byte, and decoding picks up again at the next byte. A byte
// flagged as the end of the string always gives a result with string_done
// set and clears the sequence state. Overlong forms are decoded as they
// stand. While the result register waits on the downstream side, one more
// byte is still taken into the input register; ready drops only once both
// registers are occupied.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit
  import utd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  utd_in_if.sink     byte_in,
  utd_out_if.source  char_out
);

  // Input register
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_eos;

  // Sequence state
  dec_state_t  state;
  dec_state_t  state_next;

  // Result register
  logic        res_valid;
  dec_result_t res;

  logic        dec_emit;
  dec_result_t dec_result;
  logic        advance;

  // Move the held byte through decode when the result slot is free or
  // being drained this cycle.
  assign advance       = hold_valid && (!res_valid || char_out.ready);
  assign byte_in.ready = !hold_valid || advance;

  utd_decode u_decode (
    .state         (state),
    .byte_value    (hold_byte),
    .end_of_string (hold_eos),
    .state_next    (state_next),
    .emit          (dec_emit),
    .result        (dec_result)
  );

  // Capture incoming bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_in.ready) begin
      hold_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      hold_byte <= byte_in.byte_value;
      hold_eos  <= byte_in.end_of_string;
    end
  end

  // Update sequence state once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: load on a decode that emits, drop on a taken result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= dec_emit;
    end else if (char_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_emit) begin
      res <= dec_result;
    end
  end

  assign char_out.valid       = res_valid;
  assign char_out.code_point  = res.code_point;
  assign char_out.error_kind  = res.error_kind;
  assign char_out.string_done = res.string_done;

`ifndef SYNTHESIS
  // Back-pressure only arises from a stalled result
  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> (char_out.valid && !char_out.ready))
    else $error("input stalled without a stalled result");

  // The end of a string always leaves the sequence state cleared
  a_eos_clears_state: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_eos) |=> (state.bytes_pending == 2'd0))
    else $error("sequence state open after end of string");

  // An error result carries a zero code point
  a_error_zero_code: assert property (@(posedge clk) disable iff (rst)
    (char_out.valid && (char_out.error_kind != ERR_NONE)) |-> (char_out.code_point == '0))
    else $error("error result with nonzero code point");

  // A decode that emits always fills the result slot
  a_emit_loads_result: assert property (@(posedge clk) disable iff (rst)
    (advance && dec_emit) |=> char_out.valid)
    else $error("emitted result lost");
`endif

endmodule

// ----- bench/tb_utf8_to_ucs2_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_to_ucs2_decoder_unit
// Self-checking bench for the streaming UTF-8 to 16-bit code point decoder.
// ----------------------------------------------------------------------------
// Bytes go in through the byte channel with random gaps. Every accepted byte
// runs through a behavioral decoder kept in this bench, which queues the
// character (or error) that the byte should produce. Every result taken from
// the result channel is checked field by field against the oldest queued
// character. Directed tests hit each byte class and error first. Random
// strings follow: mostly well-formed text with some corrupted strings and
// pure noise. The result side stalls at random throughout.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder_unit;
  import utd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;

  utd_in_if  byte_if ();
  utd_out_if char_if ();

  utf8_to_ucs2_decoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .char_out (char_if)
  );

  // Behavioral decoder state and the characters it still owes.
  dec_state_t  decoder_state = '0;
  dec_result_t expected_chars[$];

  int unsigned mismatch_count = 0;
  int unsigned char_index     = 0;

  // Gap control: a burst flag forces back-to-back transactions on that side.
  bit src_burst  = 1'b0;
  bit sink_burst = 1'b0;

  // Bytes of the string being built by the random test.
  logic [7:0] text_bytes[$];

  // --------------------------------------------------------------------------
  // Clock, reset, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous bound: every byte waiting out the longest gap and the longest
  // result stall, several times over.
  initial begin
    #200us;
    $display("FAIL utf8_to_ucs2_decoder_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder: consume one byte, return 1 when a result is due.
  // --------------------------------------------------------------------------
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output dec_result_t res);
    logic is_lead3;
    logic is_lead2;
    is_lead3 = (b[7:4] == LEAD3_TAG);
    is_lead2 = (b[7:5] == LEAD2_TAG);
    res = '0;
    res.error_kind  = ERR_NONE;
    res.string_done = eos;

    if (decoder_state.bytes_pending == 2'd0) begin
      if (is_lead3 || is_lead2) begin
        // A multi-byte lead cannot be the last byte of a string
        if (eos) begin
          decoder_state  = '0;
          res.error_kind = ERR_END;
          return 1'b1;
        end
        decoder_state.partial_bits  = is_lead3 ? {6'd0, b[3:0]} : {5'd0, b[4:0]};
        decoder_state.bytes_pending = is_lead3 ? 2'd2 : 2'd1;
        return 1'b0;
      end
      if (!b[7]) begin
        res.code_point = {8'h00, b};
        return 1'b1;
      end
      // Stray continuation byte or a 4-byte-and-up lead
      decoder_state  = '0;
      res.error_kind = ERR_LEAD;
      return 1'b1;
    end

    // Open sequence: the end check wins over the prefix check
    if (eos && decoder_state.bytes_pending > 2'd1) begin
      decoder_state  = '0;
      res.error_kind = ERR_END;
      return 1'b1;
    end
    if (b[7:6] != CONT_TAG) begin
      decoder_state  = '0;
      res.error_kind = ERR_CONT;
      return 1'b1;
    end
    if (decoder_state.bytes_pending > 2'd1) begin
      decoder_state.partial_bits  = {decoder_state.partial_bits[3:0], b[5:0]};
      decoder_state.bytes_pending = 2'd1;
      return 1'b0;
    end
    res.code_point = {decoder_state.partial_bits, b[5:0]};
    decoder_state  = '0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line each, capped so a broken build stays readable
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("[%0t] char %0d %s: expected 0x%0h, got 0x%0h",
               $realtime, char_index, what, want_v, got_v);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on every byte transaction, check on every result one.
  // Values are sampled at the edge, before any nonblocking update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dec_result_t predicted;
    dec_result_t want;
    if (!rst) begin
      // Predict first; results trail their bytes through the input and result registers anyway
      if (byte_if.valid && byte_if.ready) begin
        if (decode_byte(byte_if.byte_value, byte_if.end_of_string, predicted))
          expected_chars.push_back(predicted);
      end
      if (char_if.valid && char_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing pending", 0, char_if.code_point);
        end else begin
          want = expected_chars.pop_front();
          if (char_if.code_point != want.code_point)
            report_mismatch("code_point", want.code_point, char_if.code_point);
          if (char_if.error_kind != want.error_kind)
            report_mismatch("error_kind", want.error_kind, char_if.error_kind);
          if (char_if.string_done != want.string_done)
            report_mismatch("string_done", want.string_done, char_if.string_done);
        end
        char_index++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall a random number of cycles before each transaction,
  // with occasional stretches of no stall at all.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int burst_left;
    burst_left = 0;
    forever begin
      if (burst_left == 0) begin
        sink_burst = ($urandom_range(0, 4) == 0);
        burst_left = $urandom_range(4, 20);
      end
      burst_left--;
      stall = sink_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        char_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_if.ready <= 1'b1;
      // Hold ready until a result is actually taken
      do @(posedge clk); while (!char_if.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Byte side helpers
  // --------------------------------------------------------------------------

  // Send one byte. Valid stays high after the transaction so a zero gap
  // gives back-to-back bytes; a nonzero gap drops it first.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid         <= 1'b1;
    byte_if.byte_value    <= b;
    byte_if.end_of_string <= eos;
    do @(posedge clk); while (!byte_if.ready);
  endtask

  // Drop valid and hold off until every owed character has come out. Wait
  // for a clock edge first so the last byte's prediction is already queued.
  task automatic drain_results();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Send the built string, flagging its last byte as the end.
  task automatic send_text();
    foreach (text_bytes[i])
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Append one well-formed character of random length and content.
  task automatic add_random_char();
    case ($urandom_range(0, 2))
      0: text_bytes.push_back({1'b0, 7'($urandom)});
      1: begin
        text_bytes.push_back({LEAD2_TAG, 5'($urandom)});
        text_bytes.push_back({CONT_TAG, 6'($urandom)});
      end
      default: begin
        text_bytes.push_back({LEAD3_TAG, 4'($urandom)});
        text_bytes.push_back({CONT_TAG, 6'($urandom)});
        text_bytes.push_back({CONT_TAG, 6'($urandom)});
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Single-byte characters at both ends of the ASCII range.
  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  // Two-byte forms, the overlong encoding of zero included; it decodes as is.
  task automatic test_two_byte();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // Three-byte forms up to 0xFFFF. Pause with a sequence open so the
  // partial character has to survive an idle stretch.
  task automatic test_three_byte();
    send_byte(8'hE2, 1'b0);
    drain_results();
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // Stray continuation byte and a lead beyond the 3-byte forms.
  task automatic test_bad_lead();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Non-continuation byte inside a sequence: it is dropped, not reused.
  task automatic test_missing_prefix();
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hC0, 1'b0);
  endtask

  // String ends inside a sequence. The end check wins over the prefix check
  // while two continuation bytes are still owed; with one owed the prefix
  // error stands, closing the string.
  task automatic test_end_inside();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // Random strings: mostly valid text, some corrupted, some pure noise.
  task automatic test_random_strings();
    int sent;
    int string_idx;
    int n_chars;
    int pos;
    sent = 0;
    string_idx = 0;
    while (sent < 425) begin
      text_bytes.delete();
      src_burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any byte value at all
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) add_random_char();
        // Corrupt about one string in five
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, text_bytes.size() - 1);
          case ($urandom_range(0, 2))
            0:       text_bytes[pos] = 8'($urandom);
            1:       text_bytes.insert(pos, 8'($urandom));
            default: void'(text_bytes.pop_back());
          endcase
          if (text_bytes.size() == 0) text_bytes.push_back(8'($urandom));
        end
      end
      send_text();
      sent += text_bytes.size();
      string_idx++;
      // Hold off now and then until the decoder has caught up
      if (string_idx % 25 == 12) drain_results();
    end
    src_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                   <= 1'b1;
    byte_if.valid         <= 1'b0;
    byte_if.byte_value    <= '0;
    byte_if.end_of_string <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii();
    test_two_byte();
    test_three_byte();
    test_bad_lead();
    test_missing_prefix();
    test_end_inside();
    test_random_strings();

    // Drain, then idle on so that anything stray can still show up
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("characters never delivered", 0, expected_chars.size());

    if (mismatch_count == 0) begin
      $display("PASS utf8_to_ucs2_decoder_unit");
    end else begin
      $display("FAIL utf8_to_ucs2_decoder_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/utd_pkg.sv
hdl/utd_in_if.sv
hdl/utd_out_if.sv
hdl/utd_decode.sv
hdl/utf8_to_ucs2_decoder_unit.sv
bench/tb_utf8_to_ucs2_decoder_unit.sv
